>>> hdl/hlsd_pkg.sv
`default_nettype none
package hlsd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned IDX_W  = 2;

	localparam logic [LEN_W-1:0] LEN_CEILING = 16'd65529;

	localparam logic [BYTE_W-1:0] SYNC_A_RST  = 8'd190;
	localparam logic [BYTE_W-1:0] SYNC_B_RST  = 8'd239;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST = 16'd65529;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SYNC_A  = 2'd0,
		REG_SYNC_B  = 2'd1,
		REG_MAX_LEN = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_HUNT_A  = 4'b0001,
		PH_HUNT_B  = 4'b0010,
		PH_LENGTH  = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic              first;
		logic              last;
		logic [LEN_W-1:0]  len;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

>>> hdl/hlsd_front.sv
`default_nettype none
module hlsd_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [hlsd_pkg::BYTE_W-1:0]  in_byte,
	input  wire logic                         cfg_we,
	input  wire logic [hlsd_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [hlsd_pkg::CFG_W-1:0]   cfg_data,
	input  wire hlsd_pkg::q_stat_t            q_stat,
	output logic                              push,
	output hlsd_pkg::res_t                    res
);

	logic [hlsd_pkg::BYTE_W-1:0] sync_a_q, sync_b_q;
	logic [hlsd_pkg::LEN_W-1:0]  max_len_q;

	hlsd_pkg::phase_t           phase_q, phase_d;
	logic [1:0]                 idx_q, idx_d;
	logic [hlsd_pkg::LEN_W-1:0] acc_q, acc_d;
	logic                       hi_q, hi_d;
	logic [hlsd_pkg::LEN_W-1:0] rem_q, rem_d;
	logic                       first_q, first_d;

	logic                       accept;
	logic                       emit;
	logic                       hi_fin;
	logic [hlsd_pkg::LEN_W-1:0] limit;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;
	assign push     = accept && emit;
	assign hi_fin   = hi_q || (in_byte != '0);
	assign limit    = (max_len_q > hlsd_pkg::LEN_CEILING) ? hlsd_pkg::LEN_CEILING : max_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_a_q  <= hlsd_pkg::SYNC_A_RST;
			sync_b_q  <= hlsd_pkg::SYNC_B_RST;
			max_len_q <= hlsd_pkg::MAX_LEN_RST;
		end else if (cfg_we) begin
			case (hlsd_pkg::cfg_reg_t'(cfg_index))
				hlsd_pkg::REG_SYNC_A:  sync_a_q  <= cfg_data[hlsd_pkg::BYTE_W-1:0];
				hlsd_pkg::REG_SYNC_B:  sync_b_q  <= cfg_data[hlsd_pkg::BYTE_W-1:0];
				hlsd_pkg::REG_MAX_LEN: max_len_q <= cfg_data[hlsd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		acc_d     = acc_q;
		hi_d      = hi_q;
		rem_d     = rem_q;
		first_d   = first_q;
		emit      = 1'b0;
		res       = '0;
		res.kind  = hlsd_pkg::KIND_BYTE;
		unique case (phase_q)
			hlsd_pkg::PH_HUNT_B: begin
				if (in_byte == sync_b_q) begin
					phase_d = hlsd_pkg::PH_LENGTH;
					idx_d   = '0;
					acc_d   = '0;
					hi_d    = 1'b0;
				end else if (in_byte != sync_a_q) begin
					phase_d = hlsd_pkg::PH_HUNT_A;
				end
			end
			hlsd_pkg::PH_LENGTH: begin
				case (idx_q)
					2'd0: acc_d[7:0]  = in_byte;
					2'd1: acc_d[15:8] = in_byte;
					2'd2: hi_d        = (in_byte != '0);
					default: ;
				endcase
				if (idx_q != 2'd3) begin
					idx_d = idx_q + 2'd1;
				end else begin
					phase_d = hlsd_pkg::PH_HUNT_A;
					idx_d   = '0;
					acc_d   = '0;
					hi_d    = 1'b0;
					rem_d   = '0;
					first_d = 1'b0;
					if (hi_fin || (acc_q > limit)) begin
						emit     = 1'b1;
						res.kind = hlsd_pkg::KIND_ERROR;
						res.last = 1'b1;
						res.len  = (hi_fin || (acc_q > hlsd_pkg::LEN_CEILING)) ?
							hlsd_pkg::LEN_CEILING : acc_q;
					end else if (acc_q == '0) begin
						emit     = 1'b1;
						res.kind = hlsd_pkg::KIND_EMPTY;
						res.last = 1'b1;
					end else begin
						phase_d = hlsd_pkg::PH_PAYLOAD;
						acc_d   = acc_q;
						rem_d   = acc_q;
						first_d = 1'b1;
					end
				end
			end
			hlsd_pkg::PH_PAYLOAD: begin
				emit      = 1'b1;
				res.kind  = hlsd_pkg::KIND_BYTE;
				res.data  = in_byte;
				res.first = first_q;
				res.last  = (rem_q <= 16'd1);
				res.len   = acc_q;
				first_d   = 1'b0;
				if (rem_q <= 16'd1) begin
					phase_d = hlsd_pkg::PH_HUNT_A;
					idx_d   = '0;
					acc_d   = '0;
					hi_d    = 1'b0;
					rem_d   = '0;
				end else begin
					rem_d = rem_q - 16'd1;
				end
			end
			default: begin
				phase_d = (in_byte == sync_a_q) ? hlsd_pkg::PH_HUNT_B : hlsd_pkg::PH_HUNT_A;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hlsd_pkg::PH_HUNT_A;
			idx_q   <= '0;
			acc_q   <= '0;
			hi_q    <= 1'b0;
			rem_q   <= '0;
			first_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			acc_q   <= acc_d;
			hi_q    <= hi_d;
			rem_q   <= rem_d;
			first_q <= first_d;
		end
	end

endmodule
`default_nettype wire

>>> hdl/hlsd_queue.sv
`default_nettype none
module hlsd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire hlsd_pkg::res_t    din,
	input  wire logic              pop,
	output hlsd_pkg::res_t         head,
	output hlsd_pkg::q_stat_t      q_stat
);

	hlsd_pkg::res_t               mem_q [hlsd_pkg::QDEPTH];
	logic [hlsd_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [hlsd_pkg::QCNT_W-1:0]  count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == hlsd_pkg::QCNT_W'(hlsd_pkg::QDEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + hlsd_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + hlsd_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + hlsd_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - hlsd_pkg::QCNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/hlsd_back.sv
`default_nettype none
module hlsd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire hlsd_pkg::res_t              head,
	input  wire hlsd_pkg::q_stat_t           q_stat,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [1:0]                       result_kind,
	output logic [hlsd_pkg::BYTE_W-1:0]      payload_byte,
	output logic                             is_first,
	output logic                             is_last,
	output logic [hlsd_pkg::LEN_W-1:0]       frame_length
);

	hlsd_pkg::res_t out_q;
	logic           valid_q;

	assign pop = !q_stat.empty && (!valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid    = valid_q;
	assign result_kind  = out_q.kind;
	assign payload_byte = out_q.data;
	assign is_first     = out_q.first;
	assign is_last      = out_q.last;
	assign frame_length = out_q.len;

endmodule
`default_nettype wire

>>> hdl/header_length_stream_deframer.sv
// Byte-stream deframer: hunts for a two-byte sync header, reads a four-byte
// little-endian length, then passes the payload bytes with first/last marks.
// An empty frame gives one empty word, a length over max_payload_len (capped
// at 65529) gives one error word, and hunting resumes. One byte is accepted
// every cycle while in_stall is low; in_stall rises only when the four-word
// result queue between the parser and the output register is full. A result
// passes through the queue, then the output register, behind earlier words.
`default_nettype none
module header_length_stream_deframer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [hlsd_pkg::BYTE_W-1:0]  in_byte,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [1:0]                        result_kind,
	output logic [hlsd_pkg::BYTE_W-1:0]       payload_byte,
	output logic                              is_first,
	output logic                              is_last,
	output logic [hlsd_pkg::LEN_W-1:0]        frame_length,
	input  wire logic                         cfg_we,
	input  wire logic [hlsd_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [hlsd_pkg::CFG_W-1:0]   cfg_data
);

	hlsd_pkg::res_t    res;
	hlsd_pkg::res_t    head;
	hlsd_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;

	hlsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.res       (res)
	);

	hlsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (res),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	hlsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.is_first     (is_first),
		.is_last      (is_last),
		.frame_length (frame_length)
	);

endmodule
`default_nettype wire
